// File: rtl/core/gol_pkg.sv
`timescale 1ns / 1ps

package gol_pkg;

	// field widths
	localparam int WaveW    = 7;
	localparam int ThreadW  = 13;
	localparam int RegsW    = 21;
	localparam int SlotW    = 8;
	localparam int ShW      = 21;
	localparam int CapW     = 7;
	localparam int RptW     = 10;
	localparam int LimW     = 2;
	localparam int CfgIdxW  = 3;
	localparam int CfgDataW = 21;

	// derived widths
	localparam int WpbNumW  = ThreadW + 1;         // blk + wave - 1
	localparam int ProdW    = RptW + WaveW;        // regs per wave
	localparam int DivW     = 21;                  // dividend width of every divider
	localparam int ScaleW   = SlotW + WpbNumW;     // capped blocks * waves per block

	// register indexes
	typedef enum logic [CfgIdxW-1:0] {
		REG_WAVE_SIZE      = 3'd0,
		REG_MAX_BLK_THR    = 3'd1,
		REG_REGS_PER_MP    = 3'd2,
		REG_MAX_WAVES      = 3'd3,
		REG_SH_PER_MP      = 3'd4,
		REG_SH_PER_BLK     = 3'd5,
		REG_MAX_BLOCKS     = 3'd6
	} cfg_reg_t;

	// limiting resource codes
	localparam logic [LimW-1:0] LIM_UNKNOWN = 2'd0;
	localparam logic [LimW-1:0] LIM_SHARED  = 2'd1;
	localparam logic [LimW-1:0] LIM_REGS    = 2'd2;
	localparam logic [LimW-1:0] LIM_SLOTS   = 2'd3;

	// reset values
	localparam logic [WaveW-1:0]   RST_WAVE_SIZE = 7'd32;
	localparam logic [ThreadW-1:0] RST_MAX_BLK   = 13'd1024;
	localparam logic [RegsW-1:0]   RST_REGS      = 21'd196608;
	localparam logic [SlotW-1:0]   RST_WAVES     = 8'd64;
	localparam logic [ShW-1:0]     RST_SH_MP     = 21'd65536;
	localparam logic [ShW-1:0]     RST_SH_BLK    = 21'd0;
	localparam logic [CapW-1:0]    RST_MAX_BLKS  = 7'd0;

endpackage

// File: rtl/core/gpu_occupancy_limiter.sv
`timescale 1ns / 1ps

// Resident-wave calculator for one multiprocessor.
// Input channel (in_valid/in_stall) carries one launch request per word:
// block_threads, regs_per_thread, shared_bytes. Output channel
// (out_valid/out_stall) returns one word per request: resident_waves and
// limiter (0 unknown, 1 shared memory, 2 registers, 3 wave slots), in order.
// Budgets are written through cfg_we/cfg_idx/cfg_wdata; the user must write
// them only while the block is idle, which the block itself does not enforce;
// an index beyond 6 is ignored. Pipeline: one setup stage, two ranks of
// 21-stage one-bit-per-stage dividers (waves per block, register and
// shared quotients, then block counts), three stages for limit selection
// and wave scaling. Throughput is one word per cycle while in_stall is low.
// When the receiver stalls, the result holds on the outputs and one further
// word is caught in a skid register; in_stall then rises (registered) and the
// whole pipeline freezes until the skid word moves on. Nothing is dropped.
// Reset empties the pipeline and loads the default budgets.
module gpu_occupancy_limiter (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [gol_pkg::CfgIdxW-1:0]   cfg_idx,
	input  logic [gol_pkg::CfgDataW-1:0]  cfg_wdata,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [gol_pkg::ThreadW-1:0]   block_threads,
	input  logic [gol_pkg::RptW-1:0]      regs_per_thread,
	input  logic [gol_pkg::ShW-1:0]       shared_bytes,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [gol_pkg::SlotW-1:0]     resident_waves,
	output logic [gol_pkg::LimW-1:0]      limiter
);

	localparam int DivW = gol_pkg::DivW;

	// configuration registers
	logic [gol_pkg::WaveW-1:0]   wave_size_q;
	logic [gol_pkg::ThreadW-1:0] max_blk_thr_q;
	logic [gol_pkg::RegsW-1:0]   regs_per_mp_q;
	logic [gol_pkg::SlotW-1:0]   max_waves_q;
	logic [gol_pkg::ShW-1:0]     sh_per_mp_q;
	logic [gol_pkg::ShW-1:0]     sh_per_blk_q;
	logic [gol_pkg::CapW-1:0]    max_blocks_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wave_size_q   <= gol_pkg::RST_WAVE_SIZE;
			max_blk_thr_q <= gol_pkg::RST_MAX_BLK;
			regs_per_mp_q <= gol_pkg::RST_REGS;
			max_waves_q   <= gol_pkg::RST_WAVES;
			sh_per_mp_q   <= gol_pkg::RST_SH_MP;
			sh_per_blk_q  <= gol_pkg::RST_SH_BLK;
			max_blocks_q  <= gol_pkg::RST_MAX_BLKS;
		end else if (cfg_we) begin
			case (cfg_idx)
				gol_pkg::REG_WAVE_SIZE:   wave_size_q   <= cfg_wdata[gol_pkg::WaveW-1:0];
				gol_pkg::REG_MAX_BLK_THR: max_blk_thr_q <= cfg_wdata[gol_pkg::ThreadW-1:0];
				gol_pkg::REG_REGS_PER_MP: regs_per_mp_q <= cfg_wdata[gol_pkg::RegsW-1:0];
				gol_pkg::REG_MAX_WAVES:   max_waves_q   <= cfg_wdata[gol_pkg::SlotW-1:0];
				gol_pkg::REG_SH_PER_MP:   sh_per_mp_q   <= cfg_wdata[gol_pkg::ShW-1:0];
				gol_pkg::REG_SH_PER_BLK:  sh_per_blk_q  <= cfg_wdata[gol_pkg::ShW-1:0];
				gol_pkg::REG_MAX_BLOCKS:  max_blocks_q  <= cfg_wdata[gol_pkg::CapW-1:0];
				default: ;
			endcase
		end
	end

	// pipeline advance: frozen only while the skid holds a word
	logic skid_vld_q;
	logic en;
	assign en       = !skid_vld_q;
	assign in_stall = skid_vld_q;

	// stage 1: validity checks, ceiling numerator, regs per wave
	logic                          vld_s1, blk_ok_s1, rpt_zero_s1, reject_s1, shb_zero_s1;
	logic [gol_pkg::WpbNumW-1:0]   wpb_num_s1;
	logic [gol_pkg::WaveW-1:0]     wave_s1;
	logic [gol_pkg::ProdW-1:0]     prod_s1;
	logic [gol_pkg::ShW-1:0]       shb_s1;
	logic [gol_pkg::ShW-1:0]       ceil_blk;

	assign ceil_blk = (sh_per_blk_q != '0) ? sh_per_blk_q : sh_per_mp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			blk_ok_s1   <= (block_threads != '0) && (block_threads <= max_blk_thr_q)
				&& (wave_size_q != '0);
			wpb_num_s1  <= {1'b0, block_threads} + gol_pkg::WpbNumW'(wave_size_q)
				- gol_pkg::WpbNumW'(1);
			wave_s1     <= wave_size_q;
			prod_s1     <= gol_pkg::ProdW'(regs_per_thread) * gol_pkg::ProdW'(wave_size_q);
			rpt_zero_s1 <= regs_per_thread == '0;
			shb_s1      <= shared_bytes;
			shb_zero_s1 <= shared_bytes == '0;
			reject_s1   <= (shared_bytes != '0) && (shared_bytes > ceil_blk);
		end
	end

	// first divider rank: waves per block, waves by registers, blocks by shared
	logic            va, vb, vc;
	logic [DivW-1:0] qa, qb, qc;
	logic [3:0]      side_a;

	gol_div_pipe #(.NW(DivW), .DW(gol_pkg::WaveW), .SW(4)) u_div_wpb (
		.clk(clk), .arst_n(arst_n), .en(en), .in_vld(vld_s1),
		.num(DivW'(wpb_num_s1)), .den(wave_s1),
		.side_in({blk_ok_s1, rpt_zero_s1, reject_s1, shb_zero_s1}),
		.out_vld(va), .quo(qa), .side_out(side_a)
	);

	gol_div_pipe #(.NW(DivW), .DW(gol_pkg::ProdW), .SW(1)) u_div_reg (
		.clk(clk), .arst_n(arst_n), .en(en), .in_vld(vld_s1),
		.num(DivW'(regs_per_mp_q)), .den(prod_s1), .side_in(1'b0),
		.out_vld(vb), .quo(qb), .side_out()
	);

	gol_div_pipe #(.NW(DivW), .DW(gol_pkg::ShW), .SW(1)) u_div_sh (
		.clk(clk), .arst_n(arst_n), .en(en), .in_vld(vld_s1),
		.num(DivW'(sh_per_mp_q)), .den(shb_s1), .side_in(1'b0),
		.out_vld(vc), .quo(qc), .side_out()
	);

	logic                        v1;
	logic [gol_pkg::WpbNumW-1:0] wpb;
	logic [DivW-1:0]             by_reg_w;
	assign v1       = va & vb & vc;
	assign wpb      = qa[gol_pkg::WpbNumW-1:0];
	assign by_reg_w = side_a[2] ? DivW'(max_waves_q) : qb;

	// second divider rank: blocks by registers and by wave slots
	localparam int Side2W = 3 + gol_pkg::WpbNumW + DivW;
	logic              vd, ve;
	logic [DivW-1:0]   qd, qe;
	logic [Side2W-1:0] side_d;

	gol_div_pipe #(.NW(DivW), .DW(gol_pkg::WpbNumW), .SW(Side2W)) u_div_breg (
		.clk(clk), .arst_n(arst_n), .en(en), .in_vld(v1),
		.num(by_reg_w), .den(wpb),
		.side_in({side_a[3], side_a[1], side_a[0], wpb, qc}),
		.out_vld(vd), .quo(qd), .side_out(side_d)
	);

	gol_div_pipe #(.NW(DivW), .DW(gol_pkg::WpbNumW), .SW(1)) u_div_slot (
		.clk(clk), .arst_n(arst_n), .en(en), .in_vld(v1),
		.num(DivW'(max_waves_q)), .den(wpb), .side_in(1'b0),
		.out_vld(ve), .quo(qe), .side_out()
	);

	logic                        v2, blk_ok2, reject2, shb_zero2;
	logic [gol_pkg::WpbNumW-1:0] wpb2;
	logic [DivW-1:0]             by_sh_raw, by_sh, by_slot, by_reg;
	assign v2        = vd & ve;
	assign blk_ok2   = side_d[Side2W-1];
	assign reject2   = side_d[Side2W-2];
	assign shb_zero2 = side_d[Side2W-3];
	assign wpb2      = side_d[DivW +: gol_pkg::WpbNumW];
	assign by_sh_raw = side_d[DivW-1:0];
	assign by_reg    = qd;
	assign by_slot   = qe;
	assign by_sh     = shb_zero2 ? by_slot : by_sh_raw;

	// stage 3: block count and binding comparisons
	logic                        vld_s3, blk_ok_s3, reject_s3, shb_zero_s3;
	logic                        sh_bind_s3, reg_bind_s3;
	logic [gol_pkg::SlotW-1:0]   blocks_s3;
	logic [gol_pkg::WpbNumW-1:0] wpb_s3;
	logic [DivW-1:0]             min_rs, min_all;

	always_comb begin
		min_rs  = (by_reg < by_slot) ? by_reg : by_slot;
		min_all = (min_rs < by_sh) ? min_rs : by_sh;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s3 <= v2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			blk_ok_s3   <= blk_ok2;
			reject_s3   <= reject2;
			shb_zero_s3 <= shb_zero2;
			// never above by_slot, which is at most the 8-bit slot count when waves per block is nonzero
			blocks_s3   <= min_all[gol_pkg::SlotW-1:0];
			sh_bind_s3  <= (by_sh <= by_reg) && (by_sh < by_slot);
			reg_bind_s3 <= (by_reg <= by_sh) && (by_reg < by_slot);
			wpb_s3      <= wpb2;
		end
	end

	// stage 4: cap and limiter choice
	logic                        vld_s4;
	logic [gol_pkg::SlotW-1:0]   capped_s4;
	logic [gol_pkg::LimW-1:0]    lim_s4;
	logic [gol_pkg::WpbNumW-1:0] wpb_s4;
	logic [gol_pkg::SlotW-1:0]   capped;
	logic [gol_pkg::LimW-1:0]    lim;

	always_comb begin
		capped = '0;
		lim    = gol_pkg::LIM_UNKNOWN;
		if (!blk_ok_s3) begin
			lim = gol_pkg::LIM_UNKNOWN;
		end else if (reject_s3) begin
			lim = gol_pkg::LIM_SHARED;
		end else if (blocks_s3 != '0) begin
			capped = blocks_s3;
			if ((max_blocks_q != '0) && (gol_pkg::SlotW'(max_blocks_q) < blocks_s3)) begin
				capped = gol_pkg::SlotW'(max_blocks_q);
				lim    = gol_pkg::LIM_SLOTS;
			end else if (sh_bind_s3 && !shb_zero_s3) begin
				lim = gol_pkg::LIM_SHARED;
			end else if (reg_bind_s3) begin
				lim = gol_pkg::LIM_REGS;
			end else begin
				lim = gol_pkg::LIM_SLOTS;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			capped_s4 <= capped;
			lim_s4    <= lim;
			wpb_s4    <= wpb_s3;
		end
	end

	// stage 5: scale blocks back to waves, clamp to slots
	logic [gol_pkg::ScaleW-1:0] scaled;
	logic [gol_pkg::SlotW-1:0]  waves;
	assign scaled = gol_pkg::ScaleW'(capped_s4) * gol_pkg::ScaleW'(wpb_s4);
	assign waves  = (scaled < gol_pkg::ScaleW'(max_waves_q)) ?
		scaled[gol_pkg::SlotW-1:0] : max_waves_q;

	// output register and skid
	logic                       out_vld_q;
	logic [gol_pkg::SlotW-1:0]  out_waves_q, skid_waves_q;
	logic [gol_pkg::LimW-1:0]   out_lim_q, skid_lim_q;
	logic                       out_take;
	assign out_take = out_vld_q && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (skid_vld_q) begin
			if (out_take) begin
				skid_vld_q <= 1'b0;
			end
		end else if (vld_s4) begin
			if (out_vld_q && !out_take) begin
				skid_vld_q <= 1'b1;
			end else begin
				out_vld_q <= 1'b1;
			end
		end else if (out_take) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_vld_q) begin
			if (out_take) begin
				out_waves_q <= skid_waves_q;
				out_lim_q   <= skid_lim_q;
			end
		end else if (vld_s4) begin
			if (out_vld_q && !out_take) begin
				skid_waves_q <= waves;
				skid_lim_q   <= lim_s4;
			end else begin
				out_waves_q <= waves;
				out_lim_q   <= lim_s4;
			end
		end
	end

	assign out_valid      = out_vld_q;
	assign resident_waves = out_waves_q;
	assign limiter        = out_lim_q;

	// checks
	a_skid_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_vld_q |-> out_vld_q)
		else $error("skid holds a word while output register is empty");

	a_fit_has_limiter: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && (out_waves_q != '0)) |-> (out_lim_q != gol_pkg::LIM_UNKNOWN))
		else $error("nonzero resident waves with unknown limiter");

	a_waves_clamped: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q |-> (out_waves_q <= max_waves_q))
		else $error("resident waves above wave slots");

	a_ranks_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		(va == vb) && (vb == vc) && (vd == ve))
		else $error("parallel divider valids out of step");

endmodule

// File: rtl/core/gol_div_pipe.sv
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per stage, NW stages deep.
module gol_div_pipe #(
	parameter int NW = 21,
	parameter int DW = 21,
	parameter int SW = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_vld,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	input  logic [SW-1:0] side_in,
	output logic          out_vld,
	output logic [NW-1:0] quo,
	output logic [SW-1:0] side_out
);

	logic          vld_s  [0:NW];
	logic [NW-1:0] dq_s   [0:NW];
	logic [DW-1:0] rem_s  [0:NW];
	logic [DW-1:0] den_s  [0:NW];
	logic [SW-1:0] side_s [0:NW];

	assign vld_s[0]  = in_vld;
	assign dq_s[0]   = num;
	assign rem_s[0]  = '0;
	assign den_s[0]  = den;
	assign side_s[0] = side_in;

	for (genvar i = 0; i < NW; i++) begin : g_stage
		logic [DW:0] trial;
		logic [DW:0] diff;
		logic        ge;

		// shift in next dividend bit, trial subtract
		always_comb begin
			trial = {rem_s[i], dq_s[i][NW-1]};
			diff  = trial - {1'b0, den_s[i]};
			ge    = trial >= {1'b0, den_s[i]};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else if (en) begin
				vld_s[i+1] <= vld_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				dq_s[i+1]   <= {dq_s[i][NW-2:0], ge};
				rem_s[i+1]  <= ge ? diff[DW-1:0] : trial[DW-1:0];
				den_s[i+1]  <= den_s[i];
				side_s[i+1] <= side_s[i];
			end
		end
	end

	assign out_vld  = vld_s[NW];
	assign quo      = dq_s[NW];
	assign side_out = side_s[NW];

endmodule
